// ----- hw/rtl/flow_owner_direction_classifier_defines.svh -----
// Assertion macros shared by the flow owner direction classifier RTL.
`ifndef FLOW_OWNER_DIRECTION_CLASSIFIER_DEFINES_SVH
`define FLOW_OWNER_DIRECTION_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked assertion with an explicit clock and active-low reset.
`define FODC_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked assertion on the module's own clk_i and rst_ni.
`define FODC_ASSERT(label, prop, msg) \
  `FODC_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)
`else
`define FODC_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define FODC_ASSERT(label, prop, msg)
`endif

`endif

// ----- hw/rtl/fodc_pkg.sv -----
// Package with beat types and codes of the flow owner direction classifier.
`default_nettype none

package fodc_pkg;

  // Request type codes.
  localparam logic [1:0] REQ_CLASSIFY = 2'd0;
  localparam logic [1:0] REQ_IFACE_WR = 2'd1;
  localparam logic [1:0] REQ_CONN_WR  = 2'd2;

  // Direction codes.
  localparam logic [1:0] DIR_OUT     = 2'd0;
  localparam logic [1:0] DIR_IN      = 2'd1;
  localparam logic [1:0] DIR_HOST    = 2'd2;
  localparam logic [1:0] DIR_FORWARD = 2'd3;

  // Carrier codes with a fixed meaning.
  localparam logic [3:0] CARRIER_UNKNOWN = 4'd0;
  localparam logic [3:0] CARRIER_LOCAL   = 4'd1;

  // One request beat.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [5:0]  entry_index;
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic [31:0] dst_ip;
    logic [15:0] dst_port;
    logic [15:0] length;
    logic [7:0]  owner_id;
    logic [3:0]  carrier_in;
    logic        match_ports;
    logic        entry_valid;
  } req_beat_t;

  // One result beat.
  typedef struct packed {
    logic        found;
    logic [7:0]  owner_out;
    logic [1:0]  direction;
    logic [31:0] remote_ip;
    logic [15:0] peer_port;
    logic [3:0]  carrier_out;
    logic [15:0] length_out;
  } rsp_beat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fodc_stream_if.sv -----
// Valid/ready stream interface carrying one payload per beat.
`default_nettype none

interface fodc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/flow_owner_direction_classifier.sv -----
// Top level of the flow owner direction classifier.
//
// Usage: requests arrive on in_i (payload fodc_pkg::req_beat_t) and results
// leave on out_o (payload fodc_pkg::rsp_beat_t); a beat moves when valid and
// ready are both high at a rising clock edge. A classify request gives one
// result beat; interface and connection writes, and unknown request types,
// give none.
// Throughput: one request per cycle, sustained while out_o does not stall. A
// classify beat passes through the input register, the group search register
// and the output register before its result leaves on out_o.
// The connection and interface tables are flop CAMs compared in parallel in
// the input stage; the lowest valid hit is picked in groups there and the
// group winners are combined in the second stage.
// A write takes effect as it leaves the input stage, so every later classify
// sees it and every earlier one does not.
// Reset clears all valid marks of both tables and empties the pipeline; the
// table contents are undefined until written.
// When the receiver stalls, results collect in the stages behind the output
// register and requests keep being taken until all three stages are full;
// writes keep draining from the input stage in any case.
`default_nettype none
`include "flow_owner_direction_classifier_defines.svh"

module flow_owner_direction_classifier #(
  parameter int IFACE_ENTRIES = 16,
  parameter int CONN_ENTRIES  = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fodc_stream_if.sink   in_i,
  fodc_stream_if.source out_o
);
  import fodc_pkg::*;

  localparam int IW          = (IFACE_ENTRIES > 1) ? $clog2(IFACE_ENTRIES) : 1;
  localparam int CW          = (CONN_ENTRIES > 1) ? $clog2(CONN_ENTRIES) : 1;
  localparam int CONN_GRP    = 8;
  localparam int CONN_GROUPS = (CONN_ENTRIES + CONN_GRP - 1) / CONN_GRP;
  localparam int IF_GRP      = 4;
  localparam int IF_GROUPS   = (IFACE_ENTRIES + IF_GRP - 1) / IF_GRP;

  // Tables.
  logic [31:0] iface_addr_q    [IFACE_ENTRIES];
  logic [3:0]  iface_carrier_q [IFACE_ENTRIES];
  logic [IFACE_ENTRIES-1:0] iface_used_q;
  logic [31:0] conn_laddr_q    [CONN_ENTRIES];
  logic [15:0] conn_lport_q    [CONN_ENTRIES];
  logic [31:0] conn_raddr_q    [CONN_ENTRIES];
  logic [15:0] conn_rport_q    [CONN_ENTRIES];
  logic [7:0]  conn_owner_q    [CONN_ENTRIES];
  logic [CONN_ENTRIES-1:0] conn_used_q;

  // Input stage.
  logic      s0_v_q, s0_v_d;
  req_beat_t s0_q;
  logic      s0_is_cls, s0_fire;

  // Search stage.
  logic        s1_v_q, s1_v_d;
  logic [31:0] s1_src_ip_q, s1_dst_ip_q;
  logic [15:0] s1_src_port_q, s1_dst_port_q, s1_length_q;
  logic [CONN_GROUPS-1:0] s1_grp_found_q;
  logic [7:0]  s1_grp_owner_q [CONN_GROUPS];
  logic [IF_GROUPS-1:0] s1_src_hit_q, s1_dst_hit_q;
  logic [3:0]  s1_src_carr_q [IF_GROUPS];
  logic [3:0]  s1_dst_carr_q [IF_GROUPS];

  // Output stage.
  logic      out_v_q, out_v_d;
  rsp_beat_t out_q, out_d;

  logic out_free, s1_ready, in_accept;
  logic iface_wr, conn_wr;

  // Per-entry hits and group winners of the input stage.
  logic [CONN_ENTRIES-1:0]  conn_hit;
  logic [IFACE_ENTRIES-1:0] src_hit, dst_hit;
  logic [CONN_GROUPS-1:0]   grp_found;
  logic [7:0]               grp_owner [CONN_GROUPS];
  logic [IF_GROUPS-1:0]     src_grp_hit, dst_grp_hit;
  logic [3:0]               src_grp_carr [IF_GROUPS];
  logic [3:0]               dst_grp_carr [IF_GROUPS];

  // Handshake and stage advance.
  assign out_free   = !out_v_q || out_o.ready;
  assign s1_ready   = !s1_v_q || out_free;
  assign s0_is_cls  = (s0_q.req_type == REQ_CLASSIFY);
  assign s0_fire    = s0_v_q && (!s0_is_cls || s1_ready);
  assign in_i.ready = !s0_v_q || s0_fire;
  assign in_accept  = in_i.valid && in_i.ready;

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  // Valid flags of the three stages.
  always_comb begin
    s0_v_d = s0_v_q;
    if (in_accept) begin
      s0_v_d = 1'b1;
    end else if (s0_fire) begin
      s0_v_d = 1'b0;
    end
    s1_v_d = s1_v_q;
    if (s1_ready) begin
      s1_v_d = s0_v_q && s0_is_cls;
    end
    out_v_d = out_v_q;
    if (out_free) begin
      out_v_d = s1_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s0_v_q  <= s0_v_d;
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s0_q <= in_i.data;
    end
  end

  // Table writes happen as a write beat leaves the input stage.
  assign iface_wr = s0_fire && (s0_q.req_type == REQ_IFACE_WR) &&
                    (int'(s0_q.entry_index) < IFACE_ENTRIES);
  assign conn_wr  = s0_fire && (s0_q.req_type == REQ_CONN_WR) &&
                    (int'(s0_q.entry_index) < CONN_ENTRIES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iface_used_q <= '0;
      conn_used_q  <= '0;
    end else begin
      if (iface_wr) begin
        iface_used_q[IW'(s0_q.entry_index)] <= s0_q.entry_valid;
      end
      if (conn_wr) begin
        conn_used_q[CW'(s0_q.entry_index)] <= s0_q.entry_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (iface_wr) begin
      iface_addr_q[IW'(s0_q.entry_index)]    <= s0_q.src_ip;
      iface_carrier_q[IW'(s0_q.entry_index)] <= s0_q.carrier_in;
    end
    if (conn_wr) begin
      conn_laddr_q[CW'(s0_q.entry_index)] <= s0_q.src_ip;
      conn_lport_q[CW'(s0_q.entry_index)] <= s0_q.src_port;
      conn_raddr_q[CW'(s0_q.entry_index)] <= s0_q.dst_ip;
      conn_rport_q[CW'(s0_q.entry_index)] <= s0_q.dst_port;
      conn_owner_q[CW'(s0_q.entry_index)] <= s0_q.owner_id;
    end
  end

  // Parallel compare of every table entry against the packet.
  always_comb begin
    for (int k = 0; k < CONN_ENTRIES; k++) begin
      conn_hit[k] = s0_q.match_ports && conn_used_q[k] &&
        ((s0_q.src_ip == conn_laddr_q[k] && s0_q.src_port == conn_lport_q[k] &&
          s0_q.dst_ip == conn_raddr_q[k] && s0_q.dst_port == conn_rport_q[k]) ||
         (s0_q.src_ip == conn_raddr_q[k] && s0_q.src_port == conn_rport_q[k] &&
          s0_q.dst_ip == conn_laddr_q[k] && s0_q.dst_port == conn_lport_q[k]));
    end
    for (int k = 0; k < IFACE_ENTRIES; k++) begin
      src_hit[k] = iface_used_q[k] && (iface_addr_q[k] == s0_q.src_ip);
      dst_hit[k] = iface_used_q[k] && (iface_addr_q[k] == s0_q.dst_ip);
    end
  end

  // Lowest hit inside each connection group; scanning downward lets the lowest win.
  always_comb begin
    int k;
    for (int g = 0; g < CONN_GROUPS; g++) begin
      grp_found[g] = 1'b0;
      grp_owner[g] = '0;
      for (int j = CONN_GRP - 1; j >= 0; j--) begin
        k = g * CONN_GRP + j;
        if (k < CONN_ENTRIES) begin
          if (conn_hit[k]) begin
            grp_found[g] = 1'b1;
            grp_owner[g] = conn_owner_q[k];
          end
        end
      end
    end
  end

  // Lowest hit inside each interface group, for source and destination.
  always_comb begin
    int k;
    for (int g = 0; g < IF_GROUPS; g++) begin
      src_grp_hit[g]  = 1'b0;
      dst_grp_hit[g]  = 1'b0;
      src_grp_carr[g] = CARRIER_UNKNOWN;
      dst_grp_carr[g] = CARRIER_UNKNOWN;
      for (int j = IF_GRP - 1; j >= 0; j--) begin
        k = g * IF_GRP + j;
        if (k < IFACE_ENTRIES) begin
          if (src_hit[k]) begin
            src_grp_hit[g]  = 1'b1;
            src_grp_carr[g] = iface_carrier_q[k];
          end
          if (dst_hit[k]) begin
            dst_grp_hit[g]  = 1'b1;
            dst_grp_carr[g] = iface_carrier_q[k];
          end
        end
      end
    end
  end

  // Search stage register.
  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_src_ip_q    <= s0_q.src_ip;
      s1_dst_ip_q    <= s0_q.dst_ip;
      s1_src_port_q  <= s0_q.src_port;
      s1_dst_port_q  <= s0_q.dst_port;
      s1_length_q    <= s0_q.length;
      s1_grp_found_q <= grp_found;
      s1_grp_owner_q <= grp_owner;
      s1_src_hit_q   <= src_grp_hit;
      s1_dst_hit_q   <= dst_grp_hit;
      s1_src_carr_q  <= src_grp_carr;
      s1_dst_carr_q  <= dst_grp_carr;
    end
  end

  // Combine group winners and decide the direction.
  always_comb begin
    logic       found;
    logic [7:0] owner;
    logic       src_loc, dst_loc;
    logic [3:0] c_src, c_dst;
    found   = 1'b0;
    owner   = '0;
    src_loc = 1'b0;
    dst_loc = 1'b0;
    c_src   = CARRIER_UNKNOWN;
    c_dst   = CARRIER_UNKNOWN;
    for (int g = CONN_GROUPS - 1; g >= 0; g--) begin
      if (s1_grp_found_q[g]) begin
        found = 1'b1;
        owner = s1_grp_owner_q[g];
      end
    end
    for (int g = IF_GROUPS - 1; g >= 0; g--) begin
      if (s1_src_hit_q[g]) begin
        src_loc = 1'b1;
        c_src   = s1_src_carr_q[g];
      end
      if (s1_dst_hit_q[g]) begin
        dst_loc = 1'b1;
        c_dst   = s1_dst_carr_q[g];
      end
    end

    out_d.found      = found;
    out_d.owner_out  = owner;
    out_d.length_out = s1_length_q;
    case ({src_loc, dst_loc})
      2'b10: begin
        out_d.direction   = DIR_OUT;
        out_d.remote_ip   = s1_dst_ip_q;
        out_d.peer_port   = s1_dst_port_q;
        out_d.carrier_out = c_src;
      end
      2'b01: begin
        out_d.direction   = DIR_IN;
        out_d.remote_ip   = s1_src_ip_q;
        out_d.peer_port   = s1_src_port_q;
        out_d.carrier_out = c_dst;
      end
      2'b11: begin
        out_d.direction   = DIR_HOST;
        out_d.remote_ip   = s1_src_ip_q;
        out_d.peer_port   = s1_src_port_q;
        out_d.carrier_out = CARRIER_LOCAL;
      end
      default: begin
        out_d.direction   = DIR_FORWARD;
        out_d.remote_ip   = '0;
        out_d.peer_port   = '0;
        out_d.carrier_out = CARRIER_UNKNOWN;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= out_d;
    end
  end

  // Assertions.
  `FODC_ASSERT(a_no_owner_without_hit,
               out_v_q && !out_q.found |-> out_q.owner_out == 8'd0,
               "owner set without a connection hit")
  `FODC_ASSERT(a_forward_has_no_remote,
               out_v_q && out_q.direction == DIR_FORWARD |->
                 out_q.remote_ip == 32'd0 && out_q.peer_port == 16'd0 &&
                 out_q.carrier_out == CARRIER_UNKNOWN,
               "forwarded result carries an endpoint")
  `FODC_ASSERT(a_local_carrier,
               out_v_q && out_q.direction == DIR_HOST |-> out_q.carrier_out == CARRIER_LOCAL,
               "local result without local carrier")
  `FODC_ASSERT(a_result_from_search,
               $rose(out_v_q) |-> $past(s1_v_q),
               "result appeared without a beat in the search stage")
  `FODC_ASSERT(a_write_not_forwarded,
               s0_v_q && !s0_is_cls && s1_ready |=> !s1_v_q,
               "write beat reached the search stage")

endmodule

`default_nettype wire
